@@ sv/sfit_pkg.sv @@
// Shared types, constants and helpers for the sheet feed interval timing core.
package sfit_pkg;

  localparam int TIME_W = 16;
  localparam int DIV_W  = 30;
  localparam int DEN_W  = 16;
  localparam int SUM_W  = DIV_W + 1;
  localparam int MRG_W  = 10;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_PATH_LEN  = 3'd0;
  localparam logic [IDX_W-1:0] REG_REF_LEN   = 3'd1;
  localparam logic [IDX_W-1:0] REG_ADJ_SHORT = 3'd2;
  localparam logic [IDX_W-1:0] REG_ADJ_EQUAL = 3'd3;
  localparam logic [IDX_W-1:0] REG_ADJ_LONG  = 3'd4;

  localparam logic [TIME_W-1:0] PATH_LEN_RST = 16'd2700;
  localparam logic [TIME_W-1:0] REF_LEN_RST  = 16'd2970;

  localparam logic [DIV_W-1:0] SCALE_10K = 30'd10000;
  localparam logic [DIV_W-1:0] SCALE_1K  = 30'd1000;
  localparam logic [31:0]      RECIP_10  = 32'hCCCC_CCCD;
  localparam int               RECIP_SH  = 35;

  localparam logic [9:0] WT_BAND1_LO = 10'd60;
  localparam logic [9:0] WT_BAND2_LO = 10'd106;
  localparam logic [9:0] WT_BAND3_LO = 10'd177;

  localparam logic [1:0] ROW_BELOW = 2'd0;
  localparam logic [1:0] ROW_EQUAL = 2'd1;
  localparam logic [1:0] ROW_ABOVE = 2'd2;

  localparam logic [1:0] CLS_600   = 2'd0;
  localparam logic [1:0] CLS_700   = 2'd1;
  localparam logic [1:0] CLS_OTHER = 2'd2;

  localparam logic [MRG_W-1:0] MARGIN_TAB [3][3][3] = '{
    '{ '{10'd280, 10'd240, 10'd240}, '{10'd280, 10'd281, 10'd281},
       '{10'd350, 10'd550, 10'd550} },
    '{ '{10'd190, 10'd100, 10'd100}, '{10'd190, 10'd119, 10'd119},
       '{10'd302, 10'd411, 10'd411} },
    '{ '{10'd170, 10'd100, 10'd100}, '{10'd190, 10'd119, 10'd119},
       '{10'd302, 10'd411, 10'd411} }
  };

  typedef struct packed {
    logic              action;
    logic              le;
    logic              lt;
    logic [MRG_W-1:0]  margin;
    logic [TIME_W-1:0] adj;
    logic [TIME_W-1:0] cbase;
    logic [TIME_W-1:0] tamper;
    logic [TIME_W-1:0] paddle;
    logic [TIME_W-1:0] cadd;
    logic [TIME_W-1:0] init;
  } side_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [DIV_W-1:0] nq;
    logic [DEN_W-1:0] den;
  } lane_t;

  function automatic lane_t div_step(lane_t x);
    logic [DEN_W:0] sh;
    logic [DEN_W:0] dif;
    lane_t          y;
    sh  = {x.rem, x.nq[DIV_W-1]};
    dif = sh - {1'b0, x.den};
    y.den = x.den;
    if (sh >= {1'b0, x.den}) begin
      y.rem = dif[DEN_W-1:0];
      y.nq  = {x.nq[DIV_W-2:0], 1'b1};
    end else begin
      y.rem = sh[DEN_W-1:0];
      y.nq  = {x.nq[DIV_W-2:0], 1'b0};
    end
    return y;
  endfunction

endpackage

@@ sv/sfit_front.sv @@
// Operand stage: divider dividends, divisors, margin lookup and adjustment select.
module sfit_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  logic                        action,
  input  logic [15:0]                 sheet_length,
  input  logic [15:0]                 entry_speed,
  input  logic [15:0]                 finisher_speed,
  input  logic [1:0]                  speed_class,
  input  logic [9:0]                  media_weight,
  input  logic [15:0]                 compile_base_time,
  input  logic [15:0]                 tamper_open_time,
  input  logic [15:0]                 sub_paddle_time,
  input  logic [15:0]                 compile_add_time,
  input  logic [15:0]                 init_time,
  input  logic [15:0]                 path_len,
  input  logic [15:0]                 ref_len,
  input  logic [15:0]                 adj_short,
  input  logic [15:0]                 adj_equal,
  input  logic [15:0]                 adj_long,
  output logic                        out_vld,
  output logic [sfit_pkg::DIV_W-1:0]  num_a,
  output logic [sfit_pkg::DEN_W-1:0]  den_a,
  output logic [sfit_pkg::DIV_W-1:0]  num_b,
  output logic [sfit_pkg::DEN_W-1:0]  den_b,
  output sfit_pkg::side_t             side
);
  import sfit_pkg::*;

  logic              vld_r;
  logic [DIV_W-1:0]  num_a_r, num_a_nxt, num_b_r, num_b_nxt;
  logic [DEN_W-1:0]  den_a_r, den_a_nxt, den_b_r, den_b_nxt;
  side_t             side_r, side_nxt;
  logic              le, lt;
  logic [15:0]       diff;
  logic [DIV_W-1:0]  p10k, d10k, l1k;
  logic [1:0]        row, band, ci;

  always_comb begin
    le   = sheet_length <= path_len;
    lt   = sheet_length < path_len;
    diff = le ? path_len - sheet_length : sheet_length - path_len;
    p10k = DIV_W'(path_len) * SCALE_10K;
    d10k = DIV_W'(diff) * SCALE_10K;
    l1k  = DIV_W'(sheet_length) * SCALE_1K;

    if (sheet_length < ref_len) row = ROW_BELOW;
    else if (sheet_length == ref_len) row = ROW_EQUAL;
    else row = ROW_ABOVE;

    if (media_weight >= WT_BAND1_LO && media_weight < WT_BAND2_LO) band = 2'd0;
    else if (media_weight >= WT_BAND2_LO && media_weight < WT_BAND3_LO) band = 2'd1;
    else band = 2'd2;

    case (speed_class)
      CLS_600: ci = CLS_600;
      CLS_700: ci = CLS_700;
      default: ci = CLS_OTHER;
    endcase

    den_a_nxt = (entry_speed == '0) ? 16'd1 : entry_speed;
    den_b_nxt = (finisher_speed == '0) ? 16'd1 : finisher_speed;
    if (!action) begin
      num_a_nxt = p10k;
      num_b_nxt = d10k;
    end else begin
      num_a_nxt = lt ? '0 : d10k;
      num_b_nxt = lt ? l1k : p10k;
    end

    side_nxt.action = action;
    side_nxt.le     = le;
    side_nxt.lt     = lt;
    side_nxt.margin = MARGIN_TAB[ci][row][band];
    case (row)
      ROW_BELOW: side_nxt.adj = adj_short;
      ROW_EQUAL: side_nxt.adj = adj_equal;
      default:   side_nxt.adj = adj_long;
    endcase
    side_nxt.cbase  = compile_base_time;
    side_nxt.tamper = tamper_open_time;
    side_nxt.paddle = sub_paddle_time;
    side_nxt.cadd   = compile_add_time;
    side_nxt.init   = init_time;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    num_a_r <= num_a_nxt;
    num_b_r <= num_b_nxt;
    den_a_r <= den_a_nxt;
    den_b_r <= den_b_nxt;
    side_r  <= side_nxt;
  end

  assign out_vld = vld_r;
  assign num_a   = num_a_r;
  assign den_a   = den_a_r;
  assign num_b   = num_b_r;
  assign den_b   = den_b_r;
  assign side    = side_r;

endmodule

@@ sv/sfit_div.sv @@
// Two-lane restoring divider pipeline, one quotient bit per stage.
module sfit_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  logic [sfit_pkg::DIV_W-1:0]  num_a,
  input  logic [sfit_pkg::DEN_W-1:0]  den_a,
  input  logic [sfit_pkg::DIV_W-1:0]  num_b,
  input  logic [sfit_pkg::DEN_W-1:0]  den_b,
  input  sfit_pkg::side_t             in_side,
  output logic                        out_vld,
  output logic [sfit_pkg::DIV_W-1:0]  quo_a,
  output logic [sfit_pkg::DIV_W-1:0]  quo_b,
  output sfit_pkg::side_t             out_side
);
  import sfit_pkg::*;

  logic  vld_r  [DIV_W];
  lane_t a_r    [DIV_W];
  lane_t b_r    [DIV_W];
  side_t side_r [DIV_W];
  lane_t a_nxt  [DIV_W];
  lane_t b_nxt  [DIV_W];
  lane_t a_src, b_src;

  always_comb begin
    a_src.rem = '0;
    a_src.nq  = num_a;
    a_src.den = den_a;
    b_src.rem = '0;
    b_src.nq  = num_b;
    b_src.den = den_b;
    a_nxt[0]  = div_step(a_src);
    b_nxt[0]  = div_step(b_src);
    for (int i = 1; i < DIV_W; i++) begin
      a_nxt[i] = div_step(a_r[i-1]);
      b_nxt[i] = div_step(b_r[i-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_W; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
      for (int i = 1; i < DIV_W; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= in_side;
    for (int i = 1; i < DIV_W; i++) side_r[i] <= side_r[i-1];
    for (int i = 0; i < DIV_W; i++) begin
      a_r[i] <= a_nxt[i];
      b_r[i] <= b_nxt[i];
    end
  end

  assign out_vld  = vld_r[DIV_W-1];
  assign quo_a    = a_r[DIV_W-1].nq;
  assign quo_b    = b_r[DIV_W-1].nq;
  assign out_side = side_r[DIV_W-1];

endmodule

@@ sv/sfit_back.sv @@
// Combine stages: transit sum, divide by ten, base time and final time sums.
module sfit_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  logic [sfit_pkg::DIV_W-1:0]  quo_a,
  input  logic [sfit_pkg::DIV_W-1:0]  quo_b,
  input  sfit_pkg::side_t             in_side,
  output logic                        out_vld,
  output logic [15:0]                 prep_time,
  output logic [15:0]                 base_time
);
  import sfit_pkg::*;

  logic              v1_r, v2_r, v3_r, v4_r;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic              d10_r, d10_nxt;
  side_t             s1_r, s2_r, s3_r;
  logic [63:0]       prod;
  logic [TIME_W-1:0] q10_r, lo_r;
  logic              d10b_r;
  logic [TIME_W-1:0] tr;
  logic [TIME_W-1:0] base3_r, base3_nxt, add3_r, add3_nxt;
  logic [TIME_W-1:0] prep_r, base_r;

  always_comb begin
    d10_nxt = 1'b1;
    if (!in_side.action) begin
      if (in_side.le) sum_nxt = (quo_a >= quo_b) ? SUM_W'(quo_a - quo_b) : '0;
      else sum_nxt = SUM_W'(quo_a) + SUM_W'(quo_b);
    end else if (in_side.lt) begin
      sum_nxt = SUM_W'(quo_b);
      d10_nxt = 1'b0;
    end else begin
      sum_nxt = SUM_W'(quo_a) + SUM_W'(quo_b);
    end
  end

  assign prod = {32'd0, 32'(sum_r)} * {32'd0, RECIP_10};

  always_comb begin
    tr = d10b_r ? q10_r : lo_r;
    if (!s2_r.action) begin
      base3_nxt = tr + TIME_W'(s2_r.margin);
      add3_nxt  = s2_r.tamper + s2_r.paddle;
    end else begin
      base3_nxt = s2_r.cbase + tr + s2_r.adj;
      add3_nxt  = s2_r.cadd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    sum_r   <= sum_nxt;
    d10_r   <= d10_nxt;
    s1_r    <= in_side;
    q10_r   <= prod[RECIP_SH +: TIME_W];
    lo_r    <= sum_r[TIME_W-1:0];
    d10b_r  <= d10_r;
    s2_r    <= s1_r;
    base3_r <= base3_nxt;
    add3_r  <= add3_nxt;
    s3_r    <= s2_r;
    base_r  <= base3_r;
    prep_r  <= base3_r + add3_r + s3_r.init;
  end

  assign out_vld   = v4_r;
  assign prep_time = prep_r;
  assign base_time = base_r;

endmodule

@@ sv/sheet_feed_interval_timing_core.sv @@
// Top level of the sheet feed interval timing core: registers and pipeline.
//
//   channel  ports                         handshake
//   input    in_* fields, start, busy      start & !busy
//   result   out_* fields, out_strobe      one-cycle strobe
//   config   cfg_index, cfg_data           cfg_valid & cfg_ready
//
// One item per cycle; each result passes through the operand stage,
// 30 divider stages and four combine stages after its start.
// busy stays low: the pipeline never stalls and the receiver cannot stall.
// Reset clears the valid bits and loads the register defaults.
module sheet_feed_interval_timing_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [15:0] in_sheet_length,
  input  logic [15:0] in_entry_speed,
  input  logic [15:0] in_finisher_speed,
  input  logic [1:0]  in_speed_class,
  input  logic [9:0]  in_media_weight,
  input  logic [15:0] in_compile_base_time,
  input  logic [15:0] in_tamper_open_time,
  input  logic [15:0] in_sub_paddle_time,
  input  logic [15:0] in_compile_add_time,
  input  logic [15:0] in_init_time,
  output logic        out_strobe,
  output logic [15:0] out_prep_time,
  output logic [15:0] out_base_time,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [sfit_pkg::IDX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  import sfit_pkg::*;

  logic [15:0]      path_len_r, ref_len_r, adj_short_r, adj_equal_r, adj_long_r;
  logic             f_vld, d_vld;
  logic [DIV_W-1:0] num_a, num_b, quo_a, quo_b;
  logic [DEN_W-1:0] den_a, den_b;
  side_t            f_side, d_side;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      path_len_r  <= PATH_LEN_RST;
      ref_len_r   <= REF_LEN_RST;
      adj_short_r <= '0;
      adj_equal_r <= '0;
      adj_long_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PATH_LEN:  path_len_r  <= cfg_data;
        REG_REF_LEN:   ref_len_r   <= cfg_data;
        REG_ADJ_SHORT: adj_short_r <= cfg_data;
        REG_ADJ_EQUAL: adj_equal_r <= cfg_data;
        REG_ADJ_LONG:  adj_long_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  sfit_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_vld            (start && !busy),
    .action            (in_action),
    .sheet_length      (in_sheet_length),
    .entry_speed       (in_entry_speed),
    .finisher_speed    (in_finisher_speed),
    .speed_class       (in_speed_class),
    .media_weight      (in_media_weight),
    .compile_base_time (in_compile_base_time),
    .tamper_open_time  (in_tamper_open_time),
    .sub_paddle_time   (in_sub_paddle_time),
    .compile_add_time  (in_compile_add_time),
    .init_time         (in_init_time),
    .path_len          (path_len_r),
    .ref_len           (ref_len_r),
    .adj_short         (adj_short_r),
    .adj_equal         (adj_equal_r),
    .adj_long          (adj_long_r),
    .out_vld           (f_vld),
    .num_a             (num_a),
    .den_a             (den_a),
    .num_b             (num_b),
    .den_b             (den_b),
    .side              (f_side)
  );

  sfit_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (f_vld),
    .num_a    (num_a),
    .den_a    (den_a),
    .num_b    (num_b),
    .den_b    (den_b),
    .in_side  (f_side),
    .out_vld  (d_vld),
    .quo_a    (quo_a),
    .quo_b    (quo_b),
    .out_side (d_side)
  );

  sfit_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (d_vld),
    .quo_a     (quo_a),
    .quo_b     (quo_b),
    .in_side   (d_side),
    .out_vld   (out_strobe),
    .prep_time (out_prep_time),
    .base_time (out_base_time)
  );

endmodule
